/* design/i420_letterbox_resize_to_rgb_top_defines.svh */
// Assertion macros for the I420 letterbox resizer checker.
// Depends on nothing; the checker supplies clk_i and rst_ni.
`ifndef I420_LETTERBOX_RESIZE_TO_RGB_TOP_DEFINES_SVH
`define I420_LETTERBOX_RESIZE_TO_RGB_TOP_DEFINES_SVH

// Same-cycle implication.
`define I420LB_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("i420lb check failed");

// Next-cycle implication.
`define I420LB_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("i420lb check failed");

// Implication after a fixed number of cycles.
`define I420LB_ASSERT_DLY(lbl, a, n, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##n (b)) \
    else $error("i420lb check failed");

`endif

/* design/i420lb_pkg.sv */
// Shared types, constants and helpers for the I420 letterbox resizer.
// Used by every module of the block but i420lb_ram; depends on nothing.
package i420lb_pkg;

  localparam int FRAME_BYTES = 2097152;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int DIM_W       = 11;
  localparam int OFS_W       = 10;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int DIV_STAGES  = DIM_W;
  // Accept edge to the edge that samples the result strobe.
  localparam int LATENCY     = DIV_STAGES + 8;

  localparam logic [7:0] PAD_VALUE = 8'd114;
  localparam logic signed [15:0] K_BU = 16'sd29032;
  localparam logic signed [15:0] K_GU = 16'sd5636;
  localparam logic signed [15:0] K_GV = 16'sd11698;
  localparam logic signed [15:0] K_RV = 16'sd22970;

  localparam logic [2:0] CFG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_DST_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_DST_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_CROP_LEFT   = 3'd4;
  localparam logic [2:0] CFG_CROP_TOP    = 3'd5;
  localparam logic [2:0] CFG_CROP_WIDTH  = 3'd6;
  localparam logic [2:0] CFG_CROP_HEIGHT = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [OFS_W-1:0] cl;
    logic [OFS_W-1:0] ct;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]    fw;
    logic [DIM_W-1:0]    fh;
    logic [OFS_W-1:0]    pl;
    logic [OFS_W-1:0]    pt;
    logic [FRAME_AW-1:0] uoff;
    logic [FRAME_AW-1:0] voff;
  } fit_t;

  // Request fields that ride along the pipeline.
  typedef struct packed {
    logic                rd;
    logic [FRAME_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic [9:0]          x;
    logic [9:0]          y;
    logic                order;
    logic                in_win;
  } meta_t;

  localparam cfg_t CFG_RESET = '{sw: 11'd640, sh: 11'd480, dw: 11'd640, dh: 11'd640,
                                 cl: 10'd0, ct: 10'd0, cw: 11'd640, ch: 11'd480};
  localparam fit_t FIT_RESET = '{fw: 11'd640, fh: 11'd480, pl: 10'd0, pt: 10'd80,
                                 uoff: 21'd307200, voff: 21'd384000};

  // Zero-sized crop extents count as one.
  function automatic logic [DIM_W-1:0] nz(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  // Floor by 2^14 and clamp to a byte.
  function automatic logic [7:0] to_byte(input logic signed [25:0] acc);
    logic [7:0] r;
    if (acc < 0) begin
      r = 8'd0;
    end else if (acc[25:22] != 4'd0) begin
      r = 8'd255;
    end else begin
      r = acc[21:14];
    end
    return r;
  endfunction

endpackage

/* design/i420lb_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module i420lb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/i420lb_fit.sv */
// Configuration registers and the letterbox fit unit (multiply, then a
// bit-serial divide). Depends on i420lb_pkg.
module i420lb_fit import i420lb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  output cfg_t             cfg_o,
  output fit_t             fit_o,
  output logic             busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRD  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  cfg_t                cfg_q;
  fit_t                fit_q;
  logic [PROD_W-1:0]   p1_q, p2_q, area_q;
  logic                sel_q;
  logic [PROD_W:0]     num_q;
  logic [DIM_W:0]      den_q;
  logic [DIM_W+1:0]    rem_q;
  logic [4:0]          cnt_q;
  logic [DIM_W+1:0]    rem_sh;
  logic                ge;
  logic [DIM_W-1:0]    quo, fw_n, fh_n;
  logic                sel_n;
  logic [DIM_W-1:0]    den_n;

  assign rem_sh = {rem_q[DIM_W:0], num_q[PROD_W]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign quo    = num_q[DIM_W-1:0];
  assign sel_n  = p1_q <= p2_q;
  assign den_n  = sel_n ? nz(cfg_q.cw) : nz(cfg_q.ch);

  always_comb begin
    fw_n = sel_q ? cfg_q.dw : quo;
    fh_n = sel_q ? quo : cfg_q.dh;
    if (fw_n == '0) fw_n = DIM_W'(1);
    if (fh_n == '0) fh_n = DIM_W'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cfg_we_i) state_d = ST_PRD;
      ST_PRD:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'd0) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CFG_RESET;
      fit_q   <= FIT_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SRC_WIDTH:   cfg_q.sw <= cfg_data_i;
          CFG_SRC_HEIGHT:  cfg_q.sh <= cfg_data_i;
          CFG_DST_WIDTH:   cfg_q.dw <= cfg_data_i;
          CFG_DST_HEIGHT:  cfg_q.dh <= cfg_data_i;
          CFG_CROP_LEFT:   cfg_q.cl <= cfg_data_i[OFS_W-1:0];
          CFG_CROP_TOP:    cfg_q.ct <= cfg_data_i[OFS_W-1:0];
          CFG_CROP_WIDTH:  cfg_q.cw <= cfg_data_i;
          CFG_CROP_HEIGHT: cfg_q.ch <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_FIN) begin
        fit_q.fw   <= fw_n;
        fit_q.fh   <= fh_n;
        fit_q.pl   <= (fw_n > cfg_q.dw) ? '0 : OFS_W'((cfg_q.dw - fw_n) >> 1);
        fit_q.pt   <= (fh_n > cfg_q.dh) ? '0 : OFS_W'((cfg_q.dh - fh_n) >> 1);
        fit_q.uoff <= area_q[FRAME_AW-1:0];
        fit_q.voff <= FRAME_AW'(area_q + (area_q >> 2));
      end
    end
  end

  // Datapath of the fit unit: products of the freshly written registers,
  // then a restoring divide of 2*p + d by 2*d, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PRD) begin
      p1_q   <= cfg_q.dw * nz(cfg_q.ch);
      p2_q   <= cfg_q.dh * nz(cfg_q.cw);
      area_q <= cfg_q.sw * cfg_q.sh;
    end
    if (state_q == ST_MUL) begin
      sel_q <= sel_n;
      num_q <= {sel_n ? p1_q : p2_q, 1'b0} + (PROD_W + 1)'(den_n);
      den_q <= {den_n, 1'b0};
      rem_q <= '0;
      cnt_q <= 5'(PROD_W);
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      num_q <= {num_q[PROD_W-1:0], ge};
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign cfg_o  = cfg_q;
  assign fit_o  = fit_q;
  assign busy_o = (state_q != ST_IDLE) || cfg_we_i;

endmodule

/* design/i420lb_map.sv */
// Destination-to-source mapping pipeline: window test, scale multiply,
// pipelined divide and plane address generation. Depends on i420lb_pkg.
module i420lb_map import i420lb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  meta_t               meta_i,
  input  cfg_t                cfg_i,
  input  fit_t                fit_i,
  output logic                vld_o,
  output meta_t               meta_o,
  output logic [FRAME_AW-1:0] addr_y_o,
  output logic [FRAME_AW-1:0] addr_u_o,
  output logic [FRAME_AW-1:0] addr_v_o
);

  logic [DIM_W-1:0] x_ext, y_ext, dx_d, dy_d, cw_n, ch_n;
  logic             in_x, in_y;
  meta_t            m1_d;

  assign x_ext = {1'b0, meta_i.x};
  assign y_ext = {1'b0, meta_i.y};
  assign dx_d  = x_ext - {1'b0, fit_i.pl};
  assign dy_d  = y_ext - {1'b0, fit_i.pt};
  assign in_x  = (x_ext < cfg_i.dw) && (x_ext >= {1'b0, fit_i.pl}) && (dx_d < fit_i.fw);
  assign in_y  = (y_ext < cfg_i.dh) && (y_ext >= {1'b0, fit_i.pt}) && (dy_d < fit_i.fh);
  assign cw_n  = nz(cfg_i.cw);
  assign ch_n  = nz(cfg_i.ch);

  always_comb begin
    m1_d        = meta_i;
    m1_d.in_win = meta_i.rd && in_x && in_y;
  end

  // Stage 1: window test.
  logic             v1_q;
  meta_t            m1_q;
  logic [DIM_W-1:0] dx_q, dy_q;
  // Stage 2: scale product.
  logic              v2_q;
  meta_t             m2_q;
  logic [PROD_W-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    m2_q <= m1_q;
    px_q <= dx_q * cw_n;
    py_q <= dy_q * ch_n;
  end

  // Divide stages, one quotient bit each, most significant first.
  logic [DIV_STAGES-1:0] dv_q;
  meta_t                 dm_q [DIV_STAGES];
  logic [PROD_W-1:0]     rx_q [DIV_STAGES];
  logic [PROD_W-1:0]     ry_q [DIV_STAGES];
  logic [DIM_W-1:0]      qx_q [DIV_STAGES];
  logic [DIM_W-1:0]      qy_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic              v_in;
    meta_t             m_in;
    logic [PROD_W-1:0] rx_in, ry_in, fx_sh, fy_sh;
    logic [DIM_W-1:0]  qx_in, qy_in;
    logic              gx, gy;

    if (k == 0) begin : g_first
      assign v_in  = v2_q;
      assign m_in  = m2_q;
      assign rx_in = px_q;
      assign ry_in = py_q;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = dv_q[k-1];
      assign m_in  = dm_q[k-1];
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
    end

    assign fx_sh = PROD_W'(fit_i.fw) << (DIV_STAGES - 1 - k);
    assign fy_sh = PROD_W'(fit_i.fh) << (DIV_STAGES - 1 - k);
    assign gx    = rx_in >= fx_sh;
    assign gy    = ry_in >= fy_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dm_q[k] <= m_in;
      rx_q[k] <= gx ? rx_in - fx_sh : rx_in;
      ry_q[k] <= gy ? ry_in - fy_sh : ry_in;
      qx_q[k] <= qx_in | (DIM_W'(gx) << (DIV_STAGES - 1 - k));
      qy_q[k] <= qy_in | (DIM_W'(gy) << (DIV_STAGES - 1 - k));
    end
  end

  // Stage 3: clamp into the crop window and offset to source coordinates.
  logic [DIM_W-1:0] lx, ly, cwm1, chm1;
  logic [DIM_W:0]   sx_d, sy_d;

  assign cwm1 = cw_n - DIM_W'(1);
  assign chm1 = ch_n - DIM_W'(1);
  assign lx   = (qx_q[DIV_STAGES-1] > cwm1) ? cwm1 : qx_q[DIV_STAGES-1];
  assign ly   = (qy_q[DIV_STAGES-1] > chm1) ? chm1 : qy_q[DIV_STAGES-1];
  assign sx_d = {1'b0, lx} + (DIM_W + 1)'(cfg_i.cl);
  assign sy_d = {1'b0, ly} + (DIM_W + 1)'(cfg_i.ct);

  logic           v3_q;
  meta_t          m3_q;
  logic [DIM_W:0] sx_q, sy_q;
  // Stage 4: row products for luma and chroma.
  logic                  v4_q;
  meta_t                 m4_q;
  logic [DIM_W:0]        sx4_q;
  logic [2*DIM_W:0]      ya_q;
  logic [2*DIM_W-2:0]    ca_q;
  // Stage 5: final plane addresses.
  logic                  v5_q;
  meta_t                 m5_q;
  logic [FRAME_AW-1:0]   ay_q, au_q, av_q;
  logic [FRAME_AW-1:0]   uv;

  assign uv = FRAME_AW'(ca_q) + FRAME_AW'(sx4_q[DIM_W:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= dv_q[DIV_STAGES-1];
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m3_q  <= dm_q[DIV_STAGES-1];
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    m4_q  <= m3_q;
    sx4_q <= sx_q;
    ya_q  <= sy_q * cfg_i.sw;
    ca_q  <= sy_q[DIM_W:1] * cfg_i.sw[DIM_W-1:1];
    m5_q  <= m4_q;
    if (m4_q.rd) begin
      ay_q <= FRAME_AW'(ya_q) + FRAME_AW'(sx4_q);
      au_q <= fit_i.uoff + uv;
      av_q <= fit_i.voff + uv;
    end else begin
      ay_q <= m4_q.waddr;
      au_q <= m4_q.waddr;
      av_q <= m4_q.waddr;
    end
  end

  assign vld_o    = v5_q;
  assign meta_o   = m5_q;
  assign addr_y_o = ay_q;
  assign addr_u_o = au_q;
  assign addr_v_o = av_q;

endmodule

/* design/i420lb_csc.sv */
// Two-stage full-range BT.601 color conversion, padding and channel
// ordering into the result registers. Depends on i420lb_pkg.
module i420lb_csc import i420lb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  meta_t      meta_i,
  input  logic [7:0] y_i,
  input  logic [7:0] u_i,
  input  logic [7:0] v_i,
  output logic       valid_o,
  output logic [7:0] first_o,
  output logic [7:0] second_o,
  output logic [7:0] third_o,
  output logic       sampled_o,
  output logic [9:0] x_o,
  output logic [9:0] y_o
);

  logic signed [8:0]  us, vs;
  logic signed [24:0] bu_d, gu_d, gv_d, rv_d;

  assign us   = $signed({1'b0, u_i}) - 9'sd128;
  assign vs   = $signed({1'b0, v_i}) - 9'sd128;
  assign bu_d = K_BU * us;
  assign gu_d = K_GU * us;
  assign gv_d = K_GV * vs;
  assign rv_d = K_RV * vs;

  logic               v7_q;
  meta_t              m7_q;
  logic signed [25:0] yl_q;
  logic signed [24:0] bu_q, gu_q, gv_q, rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m7_q <= meta_i;
    yl_q <= $signed({4'b0, y_i, 14'b0});
    bu_q <= bu_d;
    gu_q <= gu_d;
    gv_q <= gv_d;
    rv_q <= rv_d;
  end

  logic [7:0] b_n, g_n, r_n, b_s, g_s, r_s;

  assign b_n = to_byte(yl_q + 26'(bu_q));
  assign g_n = to_byte(yl_q - 26'(gu_q) - 26'(gv_q));
  assign r_n = to_byte(yl_q + 26'(rv_q));
  assign b_s = m7_q.in_win ? b_n : PAD_VALUE;
  assign g_s = m7_q.in_win ? g_n : PAD_VALUE;
  assign r_s = m7_q.in_win ? r_n : PAD_VALUE;

  logic       valid_q, sampled_q;
  logic [7:0] first_q, second_q, third_q;
  logic [9:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v7_q && m7_q.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= m7_q.order ? r_s : b_s;
    second_q  <= g_s;
    third_q   <= m7_q.order ? b_s : r_s;
    sampled_q <= m7_q.in_win;
    x_q       <= m7_q.x;
    y_q       <= m7_q.y;
  end

  assign valid_o   = valid_q;
  assign first_o   = first_q;
  assign second_o  = second_q;
  assign third_o   = third_q;
  assign sampled_o = sampled_q;
  assign x_o       = x_q;
  assign y_o       = y_q;

endmodule

/* design/i420_letterbox_resize_to_rgb_top.sv */
// Top level of the I420 letterbox resizer: frame store, mapping pipeline,
// color conversion. Depends on i420lb_pkg, i420lb_fit, i420lb_map,
// i420lb_csc and i420lb_ram.
//
// A request is taken at each rising edge with start high and busy low; the
// pipeline takes one request every clock while busy stays low, so a stream
// of writes and reads runs at one per cycle. A write stores one byte of the
// planar I420 frame (Y, then U, then V) and returns nothing. A read returns
// exactly one pixel on the result ports, marked by result_valid_o for a
// single cycle; the receiver cannot hold results off, so it must take every
// result when it appears. Requests reach the frame store in request order,
// so a read sees every write made before it. The depth is set by the window
// test, the scale multiply, the eleven-stage pipelined divider that maps
// destination columns and rows back into the crop window, the address
// multipliers, the registered frame-store read and the two color conversion
// stages. Writing a configuration register raises busy in the same cycle and
// keeps it high while the fit unit works out the fitted size and padding
// with a bit-serial divider; write registers only while no requests are in
// flight. The frame store is three copies of a 2M x 8 RAM, one per plane
// read, and its contents are undefined until written.
module i420_letterbox_resize_to_rgb_top import i420lb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [DIM_W-1:0]    cfg_data_i,
  input  logic                opcode_i,
  input  logic [FRAME_AW-1:0] byte_address_i,
  input  logic [7:0]          byte_value_i,
  input  logic [9:0]          out_x_i,
  input  logic [9:0]          out_y_i,
  input  logic                channel_order_i,
  output logic                result_valid_o,
  output logic [7:0]          first_byte_o,
  output logic [7:0]          second_byte_o,
  output logic [7:0]          third_byte_o,
  output logic                sampled_o,
  output logic [9:0]          echo_x_o,
  output logic [9:0]          echo_y_o
);

  cfg_t                cfg;
  fit_t                fit;
  logic                accept;
  meta_t               req;
  logic                map_vld;
  meta_t               map_meta;
  logic [FRAME_AW-1:0] addr_y, addr_u, addr_v;
  logic [7:0]          y_rd, u_rd, v_rd;
  logic                ram_we;
  logic                v6_q;
  meta_t               m6_q;

  assign accept = start && !busy;

  // The window test fills in the window flag in the first stage.
  always_comb begin
    req.rd     = opcode_i;
    req.waddr  = byte_address_i;
    req.wdata  = byte_value_i;
    req.x      = out_x_i;
    req.y      = out_y_i;
    req.order  = channel_order_i;
    req.in_win = 1'b0;
  end

  i420lb_fit u_fit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .fit_o       (fit),
    .busy_o      (busy)
  );

  i420lb_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (accept),
    .meta_i   (req),
    .cfg_i    (cfg),
    .fit_i    (fit),
    .vld_o    (map_vld),
    .meta_o   (map_meta),
    .addr_y_o (addr_y),
    .addr_u_o (addr_u),
    .addr_v_o (addr_v)
  );

  // Writes go to all three copies at the same pipeline point as reads,
  // which keeps the store in request order.
  assign ram_we = !map_meta.rd;

  i420lb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram_y (
    .clk_i   (clk_i),
    .en_i    (map_vld),
    .we_i    (ram_we),
    .addr_i  (addr_y),
    .wdata_i (map_meta.wdata),
    .rdata_o (y_rd)
  );

  i420lb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram_u (
    .clk_i   (clk_i),
    .en_i    (map_vld),
    .we_i    (ram_we),
    .addr_i  (addr_u),
    .wdata_i (map_meta.wdata),
    .rdata_o (u_rd)
  );

  i420lb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram_v (
    .clk_i   (clk_i),
    .en_i    (map_vld),
    .we_i    (ram_we),
    .addr_i  (addr_v),
    .wdata_i (map_meta.wdata),
    .rdata_o (v_rd)
  );

  // Request fields wait here for the registered RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= map_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m6_q <= map_meta;
  end

  i420lb_csc u_csc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (v6_q),
    .meta_i    (m6_q),
    .y_i       (y_rd),
    .u_i       (u_rd),
    .v_i       (v_rd),
    .valid_o   (result_valid_o),
    .first_o   (first_byte_o),
    .second_o  (second_byte_o),
    .third_o   (third_byte_o),
    .sampled_o (sampled_o),
    .x_o       (echo_x_o),
    .y_o       (echo_y_o)
  );

endmodule

/* design/i420lb_checker.sv */
// Port-level checker for the I420 letterbox resizer, bound to the top.
// Depends on i420lb_pkg and the assertion macro header.
`include "i420_letterbox_resize_to_rgb_top_defines.svh"

module i420lb_checker import i420lb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                cfg_we_i,
  input logic [2:0]          cfg_index_i,
  input logic [DIM_W-1:0]    cfg_data_i,
  input logic                opcode_i,
  input logic [FRAME_AW-1:0] byte_address_i,
  input logic [7:0]          byte_value_i,
  input logic [9:0]          out_x_i,
  input logic [9:0]          out_y_i,
  input logic                channel_order_i,
  input logic                result_valid_o,
  input logic [7:0]          first_byte_o,
  input logic [7:0]          second_byte_o,
  input logic [7:0]          third_byte_o,
  input logic                sampled_o,
  input logic [9:0]          echo_x_o,
  input logic [9:0]          echo_y_o
);

  // A read comes out a fixed time later, carrying its own coordinates.
  `I420LB_ASSERT_DLY(a_read_result, start && !busy && opcode_i, LATENCY, result_valid_o && echo_x_o == $past(out_x_i, LATENCY) && echo_y_o == $past(out_y_i, LATENCY))

  // A write produces no result.
  `I420LB_ASSERT_DLY(a_write_silent, start && !busy && !opcode_i, LATENCY, !result_valid_o)

  // Padded pixels carry the pad value in every channel.
  `I420LB_ASSERT_IMP(a_pad_value, result_valid_o && !sampled_o, first_byte_o == PAD_VALUE && second_byte_o == PAD_VALUE && third_byte_o == PAD_VALUE)

  // A register write keeps requests out while the fit is recomputed.
  `I420LB_ASSERT_NXT(a_cfg_busy, cfg_we_i, busy)

endmodule

bind i420_letterbox_resize_to_rgb_top i420lb_checker u_i420lb_checker (.*);

/* tb/i420_letterbox_resize_to_rgb_top_tb.sv */
// Self-checking testbench for the I420 letterbox resizer top level.
// Depends on i420lb_pkg and i420_letterbox_resize_to_rgb_top; it keeps its own
// pixel predictor and frame store image and checks every returned pixel.
module i420_letterbox_resize_to_rgb_top_tb;
  import i420lb_pkg::*;

  // One predicted destination pixel, in the order the block returns it.
  typedef struct {
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [7:0] third_b;
    logic       smp;
    logic [9:0] ex;
    logic [9:0] ey;
  } pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [2:0]          cfg_index_i;
  logic [DIM_W-1:0]    cfg_data_i;
  logic                opcode_i;
  logic [FRAME_AW-1:0] byte_address_i;
  logic [7:0]          byte_value_i;
  logic [9:0]          out_x_i;
  logic [9:0]          out_y_i;
  logic                channel_order_i;
  logic                result_valid_o;
  logic [7:0]          first_byte_o;
  logic [7:0]          second_byte_o;
  logic [7:0]          third_byte_o;
  logic                sampled_o;
  logic [9:0]          echo_x_o;
  logic [9:0]          echo_y_o;

  i420_letterbox_resize_to_rgb_top u_top (.*);

  // Mirror of the register file and of the derived fit.
  logic [DIM_W-1:0] regs [8];
  longint unsigned  fit_w, fit_h, pad_l, pad_t;

  // Image of every frame store byte written so far.
  logic [7:0] store_img [int unsigned];

  pixel_t  pending_pixels [$];
  int      fail_count;
  bit      allow_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #(8 * 3000000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint unsigned nonzero(input longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // Fitted size and centering offsets from the current registers.
  function automatic void refit();
    longint unsigned dw, dh, cw, ch;
    dw = regs[CFG_DST_WIDTH];
    dh = regs[CFG_DST_HEIGHT];
    cw = nonzero(regs[CFG_CROP_WIDTH]);
    ch = nonzero(regs[CFG_CROP_HEIGHT]);
    if (dw * ch <= dh * cw) begin
      fit_w = dw;
      fit_h = (2 * ch * dw + cw) / (2 * cw);
    end else begin
      fit_h = dh;
      fit_w = (2 * cw * dh + ch) / (2 * ch);
    end
    if (fit_w == 0) fit_w = 1;
    if (fit_h == 0) fit_h = 1;
    pad_l = (fit_w > dw) ? 0 : (dw - fit_w) / 2;
    pad_t = (fit_h > dh) ? 0 : (dh - fit_h) / 2;
  endfunction

  // Maps a destination pixel to its Y, U and V store addresses.
  function automatic bit map_pixel(input int unsigned x, input int unsigned y,
                                   output int unsigned ya, output int unsigned ua,
                                   output int unsigned va);
    longint unsigned cw, ch, sw, sh, lx, ly, sx, sy, uoff, voff, uv;
    ya = 0;
    ua = 0;
    va = 0;
    if (!(x < regs[CFG_DST_WIDTH] && y < regs[CFG_DST_HEIGHT] && x >= pad_l &&
          x - pad_l < fit_w && y >= pad_t && y - pad_t < fit_h)) return 1'b0;
    cw = nonzero(regs[CFG_CROP_WIDTH]);
    ch = nonzero(regs[CFG_CROP_HEIGHT]);
    sw = regs[CFG_SRC_WIDTH];
    sh = regs[CFG_SRC_HEIGHT];
    lx = (x - pad_l) * cw / fit_w;
    ly = (y - pad_t) * ch / fit_h;
    if (lx > cw - 1) lx = cw - 1;
    if (ly > ch - 1) ly = ch - 1;
    sx = lx + regs[CFG_CROP_LEFT];
    sy = ly + regs[CFG_CROP_TOP];
    uoff = sw * sh;
    voff = uoff + (sw * sh) / 4;
    uv = (sy / 2) * (sw / 2) + sx / 2;
    ya = int'((sy * sw + sx) % FRAME_BYTES);
    ua = int'((uoff + uv) % FRAME_BYTES);
    va = int'((voff + uv) % FRAME_BYTES);
    return 1'b1;
  endfunction

  function automatic logic [7:0] clamp_byte(input int acc);
    if (acc < 0) return 8'd0;
    if ((acc >>> 14) > 255) return 8'd255;
    return 8'(acc >>> 14);
  endfunction

  function automatic pixel_t predict_pixel(input int unsigned x, input int unsigned y,
                                           input bit rgb);
    pixel_t p;
    int unsigned ya, ua, va;
    int luma, cb, cr;
    logic [7:0] bl, gr, rd;
    bl = PAD_VALUE;
    gr = PAD_VALUE;
    rd = PAD_VALUE;
    p.smp = map_pixel(x, y, ya, ua, va);
    if (p.smp) begin
      luma = store_img[ya];
      cb = int'(store_img[ua]) - 128;
      cr = int'(store_img[va]) - 128;
      bl = clamp_byte(luma * 16384 + 29032 * cb);
      gr = clamp_byte(luma * 16384 - 5636 * cb - 11698 * cr);
      rd = clamp_byte(luma * 16384 + 22970 * cr);
    end
    p.first_b = rgb ? rd : bl;
    p.second_b = gr;
    p.third_b = rgb ? bl : rd;
    p.ex = x[9:0];
    p.ey = y[9:0];
    return p;
  endfunction

  // Holds start low for a random burst now and then.
  task automatic maybe_idle();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Presents one request, waits for the edge that accepts it, then may idle.
  // Busy is sampled mid-cycle, where it is stable.
  task automatic send_request(input bit op, input int unsigned addr, input int unsigned val,
                              input int unsigned x, input int unsigned y, input bit rgb);
    bit was_busy;
    start <= 1'b1;
    opcode_i <= op;
    byte_address_i <= addr[FRAME_AW-1:0];
    byte_value_i <= val[7:0];
    out_x_i <= x[9:0];
    out_y_i <= y[9:0];
    channel_order_i <= rgb;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    if (op) pending_pixels.push_back(predict_pixel(x, y, rgb));
    else store_img[addr] = val[7:0];
    maybe_idle();
  endtask

  task automatic write_byte(input int unsigned addr);
    send_request(1'b0, addr, $urandom_range(0, 255), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1));
  endtask

  // A read is preceded by writes of whichever of its bytes were never loaded,
  // so the block never reads an undefined store entry.
  task automatic read_pixel(input int unsigned x, input int unsigned y, input bit rgb);
    int unsigned ya, ua, va;
    if (map_pixel(x, y, ya, ua, va)) begin
      if (!store_img.exists(ya)) write_byte(ya);
      if (!store_img.exists(ua)) write_byte(ua);
      if (!store_img.exists(va)) write_byte(va);
    end
    send_request(1'b1, $urandom_range(0, FRAME_BYTES - 1), $urandom_range(0, 255), x, y, rgb);
  endtask

  // Lets every outstanding request leave the pipeline, writes included.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    bit was_busy;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[DIM_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    regs[idx] = (idx == CFG_CROP_LEFT || idx == CFG_CROP_TOP) ? val[OFS_W-1:0] : val[DIM_W-1:0];
    refit();
  endtask

  task automatic set_config(input int unsigned sw, input int unsigned sh, input int unsigned dw,
                            input int unsigned dh, input int unsigned cl, input int unsigned ct,
                            input int unsigned cw, input int unsigned ch);
    drain_pipeline();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_CROP_LEFT, cl);
    write_reg(CFG_CROP_TOP, ct);
    write_reg(CFG_CROP_WIDTH, cw);
    write_reg(CFG_CROP_HEIGHT, ch);
  endtask

  // Reset configuration: pad band above and below, corners of the fit,
  // a column outside the destination and both channel orders.
  task automatic test_reset_defaults();
    read_pixel(0, 0, 1'b0);
    read_pixel(0, 79, 1'b1);
    read_pixel(0, 80, 1'b0);
    read_pixel(639, 80, 1'b1);
    read_pixel(639, 559, 1'b0);
    read_pixel(320, 560, 1'b1);
    read_pixel(640, 200, 1'b0);
    read_pixel(1023, 1023, 1'b1);
    // Saturating colors: bright luma with extreme chroma, then the opposite chroma.
    send_request(1'b0, 0, 8'd255, 0, 0, 1'b0);
    send_request(1'b0, 307200, 8'd0, 0, 0, 1'b0);
    send_request(1'b0, 384000, 8'd255, 0, 0, 1'b0);
    read_pixel(0, 80, 1'b0);
    read_pixel(0, 80, 1'b1);
    send_request(1'b0, 0, 8'd0, 0, 0, 1'b0);
    send_request(1'b0, 307200, 8'd255, 0, 0, 1'b0);
    send_request(1'b0, 384000, 8'd0, 0, 0, 1'b0);
    read_pixel(1, 81, 1'b0);
  endtask

  // Register extremes: largest frame and destination, the smallest window in
  // the far corner, a one-pixel destination, zero destination and crop
  // sizes, and a frame so large that plane reads wrap around the store.
  task automatic test_config_extremes();
    set_config(1024, 1024, 1024, 1024, 1022, 1022, 2, 2);
    read_pixel(0, 0, 1'b0);
    read_pixel(1023, 1023, 1'b1);
    read_pixel(512, 511, 1'b0);
    set_config(2, 2, 1, 1, 0, 0, 2, 2);
    read_pixel(0, 0, 1'b1);
    read_pixel(1, 0, 1'b0);
    set_config(4, 2, 0, 7, 0, 0, 0, 0);
    read_pixel(0, 0, 1'b0);
    read_pixel(0, 3, 1'b1);
    set_config(8, 8, 5, 3, 2, 2, 0, 3);
    read_pixel(2, 1, 1'b0);
    read_pixel(4, 2, 1'b1);
    set_config(2047, 2047, 2047, 2047, 1023, 1023, 2047, 2047);
    read_pixel(1023, 1023, 1'b0);
    read_pixel(700, 900, 1'b1);
    read_pixel(0, 0, 1'b0);
  endtask

  // Random settings, mostly small frames and windows inside the frame, with
  // a fully random register set now and then so every bit toggles.
  task automatic random_config();
    int unsigned sw, sh, cw, ch;
    if ($urandom_range(0, 5) == 0) begin
      set_config($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                 $urandom_range(0, 2047), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 2047), $urandom_range(0, 2047));
    end else begin
      sw = 2 * $urandom_range(1, 16);
      sh = 2 * $urandom_range(1, 16);
      cw = $urandom_range(1, sw);
      ch = $urandom_range(1, sh);
      set_config(sw, sh, $urandom_range(1, 48), $urandom_range(1, 48),
                 $urandom_range(0, sw - cw), $urandom_range(0, sh - ch), cw, ch);
    end
  endtask

  task automatic random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 7) == 0) begin
          read_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1));
        end else begin
          read_pixel($urandom_range(0, regs[CFG_DST_WIDTH] + 2) % 1024,
                     $urandom_range(0, regs[CFG_DST_HEIGHT] + 2) % 1024, $urandom_range(0, 1));
        end
      end else begin
        // Overwrites of live bytes now and then, otherwise anywhere.
        if (store_img.size() != 0 && $urandom_range(0, 1) == 0) begin
          int unsigned a;
          void'(store_img.first(a));
          repeat ($urandom_range(0, 20)) void'(store_img.next(a));
          write_byte(a);
        end else begin
          write_byte($urandom_range(0, FRAME_BYTES - 1));
        end
      end
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      random_traffic(130);
      // Sender holds off until every pending read has returned, then carries on.
      if (ph == 3) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending_pixels.size() != 0) @(posedge clk_i);
        random_traffic(30);
      end
    end
  endtask

  // Back-to-back requests with no gaps at all.
  task automatic test_full_rate();
    allow_idle = 1'b0;
    random_config();
    random_traffic(150);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Each strobed result is compared with the oldest predicted pixel.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual x %0d y %0d", $time,
                 echo_x_o, echo_y_o);
        fail_count++;
      end else begin
        pixel_t p;
        p = pending_pixels.pop_front();
        check_field("first_byte", p.first_b, first_byte_o);
        check_field("second_byte", p.second_b, second_byte_o);
        check_field("third_byte", p.third_b, third_byte_o);
        check_field("sampled", p.smp, sampled_o);
        check_field("echo_x", p.ex, echo_x_o);
        check_field("echo_y", p.ey, echo_y_o);
      end
    end
  end

  initial begin
    int waited;
    fail_count = 0;
    allow_idle = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SRC_WIDTH;
    cfg_data_i = '0;
    opcode_i = 1'b0;
    byte_address_i = '0;
    byte_value_i = '0;
    out_x_i = '0;
    out_y_i = '0;
    channel_order_i = 1'b0;
    regs[CFG_SRC_WIDTH] = 640;
    regs[CFG_SRC_HEIGHT] = 480;
    regs[CFG_DST_WIDTH] = 640;
    regs[CFG_DST_HEIGHT] = 640;
    regs[CFG_CROP_LEFT] = 0;
    regs[CFG_CROP_TOP] = 0;
    regs[CFG_CROP_WIDTH] = 640;
    regs[CFG_CROP_HEIGHT] = 480;
    refit();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_random_phases();
    test_full_rate();

    // Wait for the last pixels, with a bound, then let the pipe settle.
    start <= 1'b0;
    waited = 0;
    while (pending_pixels.size() != 0 && waited < 10 * LATENCY + 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $display("%0t: missing results, expected %0d more, actual 0", $time,
               pending_pixels.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/i420lb_pkg.sv
design/i420lb_ram.sv
design/i420lb_fit.sv
design/i420lb_map.sv
design/i420lb_csc.sv
design/i420_letterbox_resize_to_rgb_top.sv
design/i420lb_checker.sv
tb/i420_letterbox_resize_to_rgb_top_tb.sv
